@@ sv/gjs_pkg.sv @@
// Shared constants for the Gauss-Jordan solver: sizes, widths and fixed-point format.
// No dependencies; used by gjs_div, gauss_jordan_solver and the bench.
`timescale 1ns / 1ps

package gjs_pkg;

    localparam int MAX_UNKNOWNS = 7;
    localparam int FRAC_BITS    = 16;
    localparam int DATA_W       = 32;
    localparam int ROW_LEN      = MAX_UNKNOWNS + 1;
    localparam int STORE_DEPTH  = MAX_UNKNOWNS * ROW_LEN;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS + 1);
    localparam int CFG_W        = 3;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Store address of entry (row, col)
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
        return ADDR_W'(32'(row) * ROW_LEN + 32'(col));
    endfunction

endpackage

@@ sv/gauss_jordan_solver.sv @@
// Gauss-Jordan solver without pivoting, signed Q16.16, top level.
// Depends on gjs_pkg, gjs_ram and gjs_div.
`timescale 1ns / 1ps
//
// Usage:
//   cfg_* writes n (1..7; 0 reads as 1) and restarts loading. Write only while idle.
//   s_* takes the n by n+1 augmented matrix one coefficient per transfer, row-major.
//   After the last coefficient the block stops taking input, runs forward and
//   backward elimination and row scaling out of its coefficient store, then sends
//   the reduced matrix on m_*, row-major, m_is_last on the final entry and
//   m_status set on every entry if a zero pivot was met.
// Sequencing:
//   Loading takes one coefficient per cycle. There are n(n-1) eliminations; each
//   reads the row and pivot entries, divides unless the pivot is zero, then
//   reads, multiplies and writes each column in turn. Scaling divides each entry
//   of a row by its nonzero pivot; the shared divider (one quotient bit a cycle)
//   and the single store read port set the pace. Emission reads and captures each entry.
// Reset clears the sequencer and the output valid flag; the store is not cleared.
// A stalled receiver holds the output register; the sequencer waits for it.
// Loading of the next matrix starts as soon as the last entry is in that register.

module gauss_jordan_solver (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gjs_pkg::CFG_W-1:0]         cfg_unknown_count,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [gjs_pkg::DATA_W-1:0] s_coefficient,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [gjs_pkg::DATA_W-1:0] m_value,
    output logic                              m_is_last,
    output logic                              m_status
);

    localparam int DW = gjs_pkg::DATA_W;
    localparam int IW = gjs_pkg::IDX_W;
    localparam int AW = gjs_pkg::ADDR_W;
    localparam int FB = gjs_pkg::FRAC_BITS;

    typedef enum logic [16:0] {
        ST_LOAD = 17'b00000000000000001,
        ST_EA   = 17'b00000000000000010,
        ST_EB   = 17'b00000000000000100,
        ST_ED   = 17'b00000000000001000,
        ST_EW   = 17'b00000000000010000,
        ST_CP   = 17'b00000000000100000,
        ST_CR   = 17'b00000000001000000,
        ST_MUL  = 17'b00000000010000000,
        ST_SHF  = 17'b00000000100000000,
        ST_WR   = 17'b00000001000000000,
        ST_SP   = 17'b00000010000000000,
        ST_SV   = 17'b00000100000000000,
        ST_SR   = 17'b00001000000000000,
        ST_SS   = 17'b00010000000000000,
        ST_SW   = 17'b00100000000000000,
        ST_OR   = 17'b01000000000000000,
        ST_OC   = 17'b10000000000000000
    } state_t;

    state_t                 state_reg;
    logic [gjs_pkg::CFG_W-1:0] unk_reg;
    logic                   sing_reg;
    logic                   fwd_reg;
    logic [IW-1:0]          row_reg;
    logic [IW-1:0]          col_reg;
    logic [IW-1:0]          p_reg;
    logic [IW-1:0]          r_reg;
    logic [IW-1:0]          j_reg;
    logic signed [DW-1:0]   a_reg;
    logic signed [DW-1:0]   f_reg;
    logic signed [DW-1:0]   pj_reg;
    logic signed [DW-1:0]   rj_reg;
    logic signed [DW-1:0]   piv_reg;
    logic signed [DW-1:0]   mulv_reg;
    logic signed [2*DW-1:0] prod_reg;
    logic                   m_valid_reg;
    logic signed [DW-1:0]   m_value_reg;
    logic                   m_last_reg;
    logic                   m_status_reg;

    logic [IW-1:0]          n_eff;
    logic [IW-1:0]          nm1;
    logic                   s_xfer;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic signed [DW-1:0]   ram_rdata;
    logic                   div_start;
    logic signed [DW-1:0]   div_a;
    logic signed [DW-1:0]   div_b;
    logic                   div_busy;
    logic                   div_done;
    logic signed [DW-1:0]   div_q;
    logic signed [2*DW-1:0] prod_bias;
    logic signed [2*DW-1:0] prod_sh;
    logic signed [DW-1:0]   mul_sat;
    logic signed [DW:0]     diff;
    logic signed [DW-1:0]   diff_sat;

    // Effective n
    always_comb begin
        if (unk_reg == '0) begin
            n_eff = IW'(1);
        end else if (32'(unk_reg) > gjs_pkg::MAX_UNKNOWNS) begin
            n_eff = IW'(gjs_pkg::MAX_UNKNOWNS);
        end else begin
            n_eff = IW'(unk_reg);
        end
    end
    assign nm1 = n_eff - 1'b1;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);
    assign s_xfer    = s_valid && s_ready;

    // Product: truncate toward zero, then saturate
    assign prod_bias = prod_reg + (prod_reg[2*DW-1] ? (2*DW)'((64'd1 << FB) - 1) : '0);
    assign prod_sh   = prod_bias >>> FB;
    always_comb begin
        if (prod_sh > (2*DW)'(gjs_pkg::SAT_MAX)) begin
            mul_sat = gjs_pkg::SAT_MAX;
        end else if (prod_sh < (2*DW)'(gjs_pkg::SAT_MIN)) begin
            mul_sat = gjs_pkg::SAT_MIN;
        end else begin
            mul_sat = prod_sh[DW-1:0];
        end
    end

    // Row update: saturate the difference
    assign diff = {rj_reg[DW-1], rj_reg} - {mulv_reg[DW-1], mulv_reg};
    always_comb begin
        if (diff[DW] != diff[DW-1]) begin
            diff_sat = diff[DW] ? gjs_pkg::SAT_MIN : gjs_pkg::SAT_MAX;
        end else begin
            diff_sat = diff[DW-1:0];
        end
    end

    // Store read address
    always_comb begin
        case (state_reg)
            ST_EA:   ram_raddr = gjs_pkg::entry_addr(r_reg, p_reg);
            ST_EB:   ram_raddr = gjs_pkg::entry_addr(p_reg, p_reg);
            ST_CP:   ram_raddr = gjs_pkg::entry_addr(p_reg, j_reg);
            ST_CR:   ram_raddr = gjs_pkg::entry_addr(r_reg, j_reg);
            ST_SP:   ram_raddr = gjs_pkg::entry_addr(p_reg, p_reg);
            ST_SR:   ram_raddr = gjs_pkg::entry_addr(p_reg, j_reg);
            ST_OR:   ram_raddr = gjs_pkg::entry_addr(row_reg, col_reg);
            default: ram_raddr = '0;
        endcase
    end

    // Store write port: load, row update, scaling
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = gjs_pkg::entry_addr(row_reg, col_reg);
        ram_wdata = s_coefficient;
        case (state_reg)
            ST_LOAD: ram_we = s_xfer;
            ST_WR: begin
                ram_we    = 1'b1;
                ram_waddr = gjs_pkg::entry_addr(r_reg, j_reg);
                ram_wdata = diff_sat;
            end
            ST_SW: begin
                ram_we    = div_done;
                ram_waddr = gjs_pkg::entry_addr(p_reg, j_reg);
                ram_wdata = div_q;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // Divider operands
    assign div_start = ((state_reg == ST_ED) && (ram_rdata != '0)) || (state_reg == ST_SS);
    assign div_a     = (state_reg == ST_ED) ? a_reg : ram_rdata;
    assign div_b     = (state_reg == ST_ED) ? ram_rdata : piv_reg;

    gjs_ram #(
        .WIDTH(DW),
        .DEPTH(gjs_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gjs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (div_a),
        .b       (div_b),
        .busy    (div_busy),
        .done    (div_done),
        .q       (div_q)
    );

    // Sequencer; every store access is serialised, so no two overlap on one entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            unk_reg     <= gjs_pkg::CFG_W'(gjs_pkg::MAX_UNKNOWNS);
            sing_reg    <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // drop the output once transferred
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unk_reg   <= cfg_unknown_count;
                sing_reg  <= 1'b0;
                row_reg   <= '0;
                col_reg   <= '0;
                state_reg <= ST_LOAD;
            end else begin
                case (state_reg)
                    ST_LOAD: begin
                        if (s_xfer) begin
                            if (col_reg == n_eff) begin
                                col_reg <= '0;
                                if (row_reg == nm1) begin
                                    row_reg <= '0;
                                    p_reg   <= '0;
                                    r_reg   <= IW'(1);
                                    fwd_reg <= 1'b1;
                                    state_reg <= (n_eff == IW'(1)) ? ST_SP : ST_EA;
                                end else begin
                                    row_reg <= row_reg + 1'b1;
                                end
                            end else begin
                                col_reg <= col_reg + 1'b1;
                            end
                        end
                    end
                    ST_EA: state_reg <= ST_EB;
                    ST_EB: begin
                        a_reg     <= ram_rdata;
                        state_reg <= ST_ED;
                    end
                    ST_ED: begin
                        j_reg <= '0;
                        if (ram_rdata == '0) begin
                            sing_reg  <= 1'b1;
                            f_reg     <= '0;
                            state_reg <= ST_CP;
                        end else begin
                            state_reg <= ST_EW;
                        end
                    end
                    ST_EW: begin
                        if (div_done) begin
                            f_reg     <= div_q;
                            state_reg <= ST_CP;
                        end
                    end
                    ST_CP: state_reg <= ST_CR;
                    ST_CR: begin
                        pj_reg    <= ram_rdata;
                        state_reg <= ST_MUL;
                    end
                    ST_MUL: begin
                        rj_reg    <= ram_rdata;
                        prod_reg  <= pj_reg * f_reg;
                        state_reg <= ST_SHF;
                    end
                    ST_SHF: begin
                        mulv_reg  <= mul_sat;
                        state_reg <= ST_WR;
                    end
                    ST_WR: begin
                        if (j_reg != n_eff) begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_CP;
                        end else if (fwd_reg) begin
                            state_reg <= ST_EA;
                            if (r_reg != nm1) begin
                                r_reg <= r_reg + 1'b1;
                            end else if (p_reg + IW'(2) < n_eff) begin
                                p_reg <= p_reg + 1'b1;
                                r_reg <= p_reg + IW'(2);
                            end else begin
                                fwd_reg <= 1'b0;
                                p_reg   <= nm1;
                                r_reg   <= nm1 - 1'b1;
                            end
                        end else begin
                            if (r_reg != '0) begin
                                r_reg     <= r_reg - 1'b1;
                                state_reg <= ST_EA;
                            end else if (p_reg > IW'(1)) begin
                                p_reg     <= p_reg - 1'b1;
                                r_reg     <= p_reg - IW'(2);
                                state_reg <= ST_EA;
                            end else begin
                                p_reg     <= '0;
                                state_reg <= ST_SP;
                            end
                        end
                    end
                    ST_SP: state_reg <= ST_SV;
                    ST_SV: begin
                        j_reg   <= '0;
                        piv_reg <= ram_rdata;
                        if (ram_rdata == '0) begin
                            sing_reg <= 1'b1;
                            if (p_reg == nm1) begin
                                state_reg <= ST_OR;
                            end else begin
                                p_reg     <= p_reg + 1'b1;
                                state_reg <= ST_SP;
                            end
                        end else begin
                            state_reg <= ST_SR;
                        end
                    end
                    ST_SR: state_reg <= ST_SS;
                    ST_SS: state_reg <= ST_SW;
                    ST_SW: begin
                        if (div_done) begin
                            if (j_reg != n_eff) begin
                                j_reg     <= j_reg + 1'b1;
                                state_reg <= ST_SR;
                            end else if (p_reg == nm1) begin
                                state_reg <= ST_OR;
                            end else begin
                                p_reg     <= p_reg + 1'b1;
                                state_reg <= ST_SP;
                            end
                        end
                    end
                    ST_OR: begin
                        // hold until the output register is free
                        if (!m_valid_reg) begin
                            state_reg <= ST_OC;
                        end
                    end
                    ST_OC: begin
                        m_valid_reg  <= 1'b1;
                        m_value_reg  <= ram_rdata;
                        m_status_reg <= sing_reg;
                        m_last_reg   <= (row_reg == nm1) && (col_reg == n_eff);
                        state_reg    <= ST_OR;
                        if (col_reg == n_eff) begin
                            col_reg <= '0;
                            if (row_reg == nm1) begin
                                row_reg   <= '0;
                                sing_reg  <= 1'b0;
                                state_reg <= ST_LOAD;
                            end else begin
                                row_reg <= row_reg + 1'b1;
                            end
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                    default: state_reg <= ST_LOAD;
                endcase
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_value   = m_value_reg;
    assign m_is_last = m_last_reg;
    assign m_status  = m_status_reg;

`ifndef SYNTHESIS
    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_row_not_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR) |-> (r_reg != p_reg))
        else $error("row update targets its own pivot row");

    a_out_from_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OC))
        else $error("output raised outside capture");

    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == ST_LOAD) && !m_valid_reg)
        else $error("reset left sequencer or output busy");
`endif

endmodule

@@ sv/gjs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 56
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/gjs_div.sv @@
// Iterative fixed-point divider: (a * 2^FRAC_BITS) / b, truncated toward zero, saturated.
// One quotient bit per cycle. Depends on gjs_pkg.
`timescale 1ns / 1ps

module gjs_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [gjs_pkg::DATA_W-1:0] a,
    input  logic signed [gjs_pkg::DATA_W-1:0] b,
    output logic                             busy,
    output logic                             done,
    output logic signed [gjs_pkg::DATA_W-1:0] q
);

    localparam int NUM_W = gjs_pkg::DATA_W + gjs_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic                         neg_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [gjs_pkg::DATA_W-1:0]   rem_reg;
    logic [gjs_pkg::DATA_W-1:0]   den_reg;
    logic [NUM_W-1:0]             quo_reg;

    logic [gjs_pkg::DATA_W-1:0]   mag_a;
    logic [gjs_pkg::DATA_W-1:0]   mag_b;
    logic [gjs_pkg::DATA_W:0]     trial;
    logic                         ge;
    logic [gjs_pkg::DATA_W-1:0]   rem_next;

    // Magnitudes of the operands
    assign mag_a = a[gjs_pkg::DATA_W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[gjs_pkg::DATA_W-1] ? (~b + 1'b1) : b;

    // One restoring step
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? gjs_pkg::DATA_W'(trial - {1'b0, den_reg})
                         : trial[gjs_pkg::DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= {mag_a, {gjs_pkg::FRAC_BITS{1'b0}}};
                den_reg  <= mag_b;
                neg_reg  <= a[gjs_pkg::DATA_W-1] ^ b[gjs_pkg::DATA_W-1];
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Sign and saturate the quotient
    always_comb begin
        if (neg_reg) begin
            if (quo_reg > NUM_W'({1'b1, {(gjs_pkg::DATA_W-1){1'b0}}})) begin
                q = gjs_pkg::SAT_MIN;
            end else begin
                q = ~quo_reg[gjs_pkg::DATA_W-1:0] + 1'b1;
            end
        end else begin
            if (quo_reg > NUM_W'(gjs_pkg::SAT_MAX)) begin
                q = gjs_pkg::SAT_MAX;
            end else begin
                q = quo_reg[gjs_pkg::DATA_W-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for gauss_jordan_solver: directed and random augmented matrices.
// Depends on gjs_pkg and the solver RTL; keeps its own fixed-point model of the solve.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT  = 80000;
    localparam int DATA_W       = gjs_pkg::DATA_W;
    localparam int CFG_W        = gjs_pkg::CFG_W;
    localparam int FRAC_BITS    = gjs_pkg::FRAC_BITS;
    localparam int MAX_UNKNOWNS = gjs_pkg::MAX_UNKNOWNS;
    localparam int ROW_LEN      = gjs_pkg::ROW_LEN;
    localparam int STORE_DEPTH  = gjs_pkg::STORE_DEPTH;
    localparam logic signed [DATA_W-1:0] SAT_MAX = gjs_pkg::SAT_MAX;
    localparam logic signed [DATA_W-1:0] SAT_MIN = gjs_pkg::SAT_MIN;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
        logic                     status;
    } reduced_entry_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_unknown_count;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_coefficient;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_value;
    logic                     m_is_last;
    logic                     m_status;

    // Model state: coefficient store, load position, zero-pivot flag, size register
    logic signed [DATA_W-1:0] model_store [STORE_DEPTH];
    int                       model_loaded;
    bit                       model_singular;
    logic [CFG_W-1:0]         model_size_reg;

    reduced_entry_t           pending_entries [$];
    int                       mismatch_count;
    int                       coef_sent;
    int                       entries_checked;
    int                       matrices_solved;
    int                       singular_seen;
    int                       burst_left;
    int                       idle_cycles;
    bit                       run_done;

    gauss_jordan_solver i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_unknown_count (cfg_unknown_count),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_coefficient     (s_coefficient),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_value           (m_value),
        .m_is_last         (m_is_last),
        .m_status          (m_status)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // ---------------- fixed-point model ----------------

    function automatic logic signed [DATA_W-1:0] clamp32(input longint x);
        if (x > longint'(SAT_MAX)) return SAT_MAX;
        if (x < longint'(SAT_MIN)) return SAT_MIN;
        return x[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] q_mul(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        longint p;
        longint q;
        p = longint'(a) * longint'(b);
        q = (p >= 0) ? (p >>> FRAC_BITS) : -((-p) >>> FRAC_BITS);
        return clamp32(q);
    endfunction

    function automatic logic signed [DATA_W-1:0] q_div(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        longint num;
        if (b == 0) begin
            model_singular = 1'b1;
            return '0;
        end
        num = longint'(a) * (longint'(1) << FRAC_BITS);
        return clamp32(num / longint'(b));
    endfunction

    function automatic int size_in_use();
        int n;
        n = int'(model_size_reg);
        if (n == 0) n = 1;
        if (n > MAX_UNKNOWNS) n = MAX_UNKNOWNS;
        return n;
    endfunction

    // Subtract a multiple of pivot row p from row r
    function automatic void cancel_row(input int r, input int p, input int n);
        logic signed [DATA_W-1:0] f;
        f = q_div(model_store[r*ROW_LEN+p], model_store[p*ROW_LEN+p]);
        for (int j = 0; j <= n; j++)
            model_store[r*ROW_LEN+j] = clamp32(longint'(model_store[r*ROW_LEN+j])
                                       - longint'(q_mul(model_store[p*ROW_LEN+j], f)));
    endfunction

    function automatic void reduce_matrix(input int n);
        logic signed [DATA_W-1:0] piv;
        for (int p = 0; p < n; p++)
            for (int r = p + 1; r < n; r++)
                cancel_row(r, p, n);
        for (int p = n - 1; p >= 1; p--)
            for (int r = p - 1; r >= 0; r--)
                cancel_row(r, p, n);
        for (int p = 0; p < n; p++) begin
            piv = model_store[p*ROW_LEN+p];
            if (piv == 0) begin
                model_singular = 1'b1;
            end else begin
                for (int j = 0; j <= n; j++)
                    model_store[p*ROW_LEN+j] = q_div(model_store[p*ROW_LEN+j], piv);
            end
        end
    endfunction

    // Take one accepted coefficient; queue the reduced matrix when it completes a load
    function automatic void load_coefficient(input logic signed [DATA_W-1:0] c);
        int n;
        int total;
        reduced_entry_t e;
        n = size_in_use();
        total = n * (n + 1);
        if (model_loaded >= total) model_loaded = 0;
        model_store[(model_loaded / (n + 1)) * ROW_LEN + model_loaded % (n + 1)] = c;
        model_loaded++;
        if (model_loaded < total) return;
        reduce_matrix(n);
        for (int k = 0; k < total; k++) begin
            e.value   = model_store[(k / (n + 1)) * ROW_LEN + k % (n + 1)];
            e.is_last = (k + 1 == total);
            e.status  = model_singular;
            pending_entries.push_back(e);
        end
        if (model_singular) singular_seen++;
        matrices_solved++;
        model_loaded = 0;
        model_singular = 1'b0;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_coefficient(input logic signed [DATA_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_coefficient <= c;
        do @(posedge aclk); while (!s_ready);
        load_coefficient(c);
        coef_sent++;
        burst_left--;
    endtask

    // Drop valid and let every queued entry drain before touching the register
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid         <= 1'b1;
        cfg_unknown_count <= value;
        do @(posedge aclk); while (!cfg_ready);
        model_size_reg = value;
        model_loaded   = 0;
        model_singular = 1'b0;
        cfg_valid <= 1'b0;
    endtask

    // style 0: diagonally dominant, 1: any 32-bit value, 2: dominant with a zero row
    function automatic logic signed [DATA_W-1:0] pick_coefficient(input int r, input int c,
                                                                  input int n, input int style,
                                                                  input int zero_row);
        logic signed [DATA_W-1:0] v;
        if (style == 1) return $urandom;
        if (style == 2 && r == zero_row && c < n) return '0;
        if (c == n) begin
            v = $urandom_range(0, 32'h00ff_ffff);
        end else if (r == c) begin
            v = ($urandom_range(4, 96) << FRAC_BITS) | $urandom_range(0, 16'hffff);
        end else begin
            v = $urandom_range(0, 32'h0001_ffff);
        end
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic send_matrix(input int style);
        int n;
        int zero_row;
        n = size_in_use();
        zero_row = $urandom_range(0, n - 1);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
                send_coefficient(pick_coefficient(r, c, n, style, zero_row));
    endtask

    // ---------------- tests ----------------

    // Reset size of seven, full store
    task automatic test_reset_size();
        send_matrix(0);
    endtask

    // One unknown: register value zero reads as one; extremes, zero pivot, saturation
    task automatic test_single_unknown_extremes();
        write_size('0);
        send_coefficient(32'sh0001_0000);
        send_coefficient(SAT_MAX);
        send_coefficient(SAT_MIN);
        send_coefficient(SAT_MAX);
        send_coefficient(32'sh0000_0001);
        send_coefficient(SAT_MIN);
        send_coefficient('0);
        send_coefficient(32'sh0005_0000);
        send_coefficient(32'shffff_ffff);
        send_coefficient(SAT_MIN);
        write_size(3'd1);
        send_coefficient(SAT_MIN);
        send_coefficient(32'sh0000_0000);
    endtask

    // Zero leading pivot with two unknowns
    task automatic test_zero_pivot();
        write_size(3'd2);
        send_coefficient('0);
        send_coefficient(32'sh0002_0000);
        send_coefficient(32'sh0003_0000);
        send_coefficient(32'sh0001_0000);
        send_coefficient(32'sh0004_0000);
        send_coefficient(32'sh0005_0000);
    endtask

    // A register write part way through a load discards what was loaded
    task automatic test_restart_on_write();
        write_size(3'd3);
        repeat (5) send_coefficient($urandom);
        write_size(3'd2);
        send_matrix(0);
    endtask

    task automatic test_random_systems();
        int roll;
        int style;
        while (coef_sent < 460) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) write_size(CFG_W'($urandom_range(1, 3)));
            else if (roll < 42) write_size(CFG_W'($urandom_range(4, 6)));
            else if (roll < 47) write_size(3'd7);
            else if (roll < 50) write_size('0);
            roll  = $urandom_range(0, 99);
            style = (roll < 75) ? 0 : (roll < 90) ? 1 : 2;
            send_matrix(style);
        end
    endtask

    // ---------------- receiver, checker, watchdog ----------------

    // Stall pattern: randomly chosen windows of no stall, light stall and heavy stall
    int stall_mode;
    int stall_window;
    always @(posedge aclk) begin
        if (stall_window == 0) begin
            stall_window <= $urandom_range(50, 400);
            stall_mode   <= $urandom_range(0, 2);
        end else begin
            stall_window <= stall_window - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 99) >= 25);
            default: m_ready <= ($urandom_range(0, 99) >= 80);
        endcase
    end

    // Compare each result transfer against the oldest expected entry
    always @(posedge aclk) begin
        reduced_entry_t e;
        if (aresetn && m_valid && m_ready) begin
            entries_checked++;
            if (pending_entries.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected entry: value=%h last=%b status=%b",
                             m_value, m_is_last, m_status);
            end else begin
                e = pending_entries.pop_front();
                if (m_value !== e.value || m_is_last !== e.is_last || m_status !== e.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("entry %0d mismatch: exp value=%h last=%b status=%b, got %h %b %b",
                                 entries_checked, e.value, e.is_last, e.status,
                                 m_value, m_is_last, m_status);
                end
            end
        end
    end

    // Give up when nothing has moved for too long
    always @(posedge aclk) begin
        if (!aresetn || run_done || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_unknown_count = '0;
        s_valid           = 1'b0;
        s_coefficient     = '0;
        m_ready           = 1'b0;
        stall_mode        = 0;
        stall_window      = 0;
        idle_cycles       = 0;
        run_done          = 1'b0;
        mismatch_count    = 0;
        coef_sent         = 0;
        entries_checked   = 0;
        matrices_solved   = 0;
        singular_seen     = 0;
        burst_left        = 0;
        model_loaded      = 0;
        model_singular    = 1'b0;
        model_size_reg    = 3'd7;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_size();
        test_single_unknown_extremes();
        test_zero_pivot();
        test_restart_on_write();
        test_random_systems();

        wait_idle();
        run_done = 1'b1;
        if (pending_entries.size() != 0) mismatch_count++;
        $display("covered %0d coefficients, %0d matrices (%0d singular), %0d entries checked",
                 coef_sent, matrices_solved, singular_seen, entries_checked);
        $display("sizes 1 to 7 with register writes between loads; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/gjs_pkg.sv
sv/gjs_ram.sv
sv/gjs_div.sv
sv/gauss_jordan_solver.sv
bench/tb_top.sv
